// File: rtl/core/rgba_ob_pkg.sv
// Shared types and constants for the RGBA over/blend pipeline.
package rgba_ob_pkg;

    typedef enum logic {
        CMD_OVER  = 1'b0,
        CMD_BLEND = 1'b1
    } t_cmd;

    // color channels that go through the divider (red, green, blue)
    localparam int LANES = 3;

endpackage

// File: rtl/core/rgba8_over_and_blend.sv
// Top level: RGBA over-composite and weighted blend, one pixel per clock unless stalled.
// One beat in, one beat out, in order. Throughput is one pixel per clock while the output
// accepts data; the pipeline is four operand/multiply/sum stages, then one stage per quotient bit
// of the restoring divider that turns premultiplied sums back into straight color.
// Every stage has its own valid bit and advances when its successor can take data,
// so bubbles collapse and output backpressure stalls without loss.
module rgba8_over_and_blend #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // front_red, front_green, front_blue, front_alpha,
    // back_red, back_green, back_blue, back_alpha, weight
    input  logic [((9*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CB  = CHANNEL_BITS;
    localparam int NL  = rgba_ob_pkg::LANES;
    localparam int OW  = ((4 * CB + 7) / 8) * 8;
    localparam logic [CB-1:0] M = '1;

    logic [CB-1:0] in_f [0:3];
    logic [CB-1:0] in_b [0:3];
    logic [CB-1:0] in_w;
    logic [CB-1:0] sel_w;
    logic [CB-1:0] sel_ta;
    logic [CB-1:0] fc_z [0:NL-1];
    logic [CB-1:0] bc_z [0:NL-1];
    rgba_ob_pkg::t_cmd in_cmd;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_f[k] = s_axis_tdata[k*CB +: CB];
            in_b[k] = s_axis_tdata[(k+4)*CB +: CB];
        end
        in_w   = s_axis_tdata[8*CB +: CB];
        in_cmd = rgba_ob_pkg::t_cmd'(s_axis_tuser);
        for (int l = 0; l < NL; l++) begin
            fc_z[l] = (in_f[3] == '0) ? '0 : in_f[l];
            bc_z[l] = (in_b[3] == '0) ? '0 : in_b[l];
        end
        // over folds into the lerp: transparent back -> full weight on front,
        // otherwise weight front alpha onto an opaque front
        case (in_cmd)
            rgba_ob_pkg::CMD_OVER: begin
                sel_w  = (in_b[3] == '0) ? M : in_f[3];
                sel_ta = (in_b[3] == '0) ? in_f[3] : M;
            end
            rgba_ob_pkg::CMD_BLEND: begin
                sel_w  = in_w;
                sel_ta = in_f[3];
            end
            default: begin
                sel_w  = in_w;
                sel_ta = in_f[3];
            end
        endcase
    end

    // stage 1: selected operands
    logic          r1_vld;
    logic [CB-1:0] r1_w, r1_fa, r1_ta;
    logic [CB-1:0] r1_fc [0:NL-1];
    logic [CB-1:0] r1_tc [0:NL-1];
    // stage 2: alpha weights
    logic            r2_vld;
    logic [2*CB-1:0] r2_a0, r2_a1;
    logic [CB-1:0]   r2_fc [0:NL-1];
    logic [CB-1:0]   r2_tc [0:NL-1];
    // stage 3: new alpha and premultiplied terms
    logic            r3_vld;
    logic [2*CB-1:0] r3_na;
    logic [3*CB-1:0] r3_p0 [0:NL-1];
    logic [3*CB-1:0] r3_p1 [0:NL-1];
    // stage 4: numerators
    logic            r4_vld;
    logic [2*CB-1:0] r4_na;
    logic [NL-1:0][3*CB-1:0] r4_p;

    logic rdy1, rdy2, rdy3, rdy4, div_rdy;
    assign rdy4 = !r4_vld || div_rdy;
    assign rdy3 = !r3_vld || rdy4;
    assign rdy2 = !r2_vld || rdy3;
    assign rdy1 = !r1_vld || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (rdy1) r1_vld <= s_axis_tvalid;
            if (rdy2) r2_vld <= r1_vld;
            if (rdy3) r3_vld <= r2_vld;
            if (rdy4) r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r1_w  <= sel_w;
            r1_fa <= in_b[3];
            r1_ta <= sel_ta;
            for (int l = 0; l < NL; l++) begin
                r1_fc[l] <= bc_z[l];
                r1_tc[l] <= fc_z[l];
            end
        end
        if (rdy2 && r1_vld) begin
            r2_a0 <= (M - r1_w) * r1_fa;
            r2_a1 <= r1_w * r1_ta;
            for (int l = 0; l < NL; l++) begin
                r2_fc[l] <= r1_fc[l];
                r2_tc[l] <= r1_tc[l];
            end
        end
        if (rdy3 && r2_vld) begin
            r3_na <= r2_a0 + r2_a1;
            for (int l = 0; l < NL; l++) begin
                r3_p0[l] <= r2_a0 * r2_fc[l];
                r3_p1[l] <= r2_a1 * r2_tc[l];
            end
        end
        if (rdy4 && r3_vld) begin
            r4_na <= r3_na;
            for (int l = 0; l < NL; l++) begin
                r4_p[l] <= r3_p0[l] + r3_p1[l];
            end
        end
    end

    logic [NL-1:0][CB-1:0] div_q;
    logic [CB-1:0]         div_alpha;

    rgba_ob_divider #(
        .CHANNEL_BITS(CB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r4_vld),
        .o_rdy   (div_rdy),
        .i_p     (r4_p),
        .i_na    (r4_na),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_q     (div_q),
        .o_alpha (div_alpha)
    );

    assign m_axis_tdata = OW'({div_alpha, div_q[2], div_q[1], div_q[0]});

endmodule

// File: rtl/core/rgba_ob_divider.sv
// Pipelined restoring divider: three color quotients sharing one divisor, plus alpha = na / M.
module rgba_ob_divider #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    output logic                                   o_rdy,
    input  logic [rgba_ob_pkg::LANES-1:0][3*CHANNEL_BITS-1:0] i_p,
    input  logic [2*CHANNEL_BITS-1:0]              i_na,
    output logic                                   o_vld,
    input  logic                                   i_rdy,
    output logic [rgba_ob_pkg::LANES-1:0][CHANNEL_BITS-1:0]   o_q,
    output logic [CHANNEL_BITS-1:0]                o_alpha
);

    localparam int CB = CHANNEL_BITS;
    localparam int NL = rgba_ob_pkg::LANES;
    localparam int PW = 3 * CB;
    localparam int DW = 3 * CB + 1;
    localparam int NW = 2 * CB;
    localparam logic [CB-1:0] M = '1;

    // stage s settles quotient bit CB-s; bit CB set means saturate
    logic          r_vld  [0:CB];
    logic [DW-1:0] r_rem  [0:CB][0:NL-1];
    logic [CB:0]   r_q    [0:CB][0:NL-1];
    logic [NW-1:0] r_na   [0:CB];
    logic [CB-1:0] r_aq   [0:CB];
    logic          r_nz   [0:CB];
    logic          rdy    [0:CB+1];

    assign rdy[CB+1] = i_rdy;
    assign o_rdy     = rdy[0];

    for (genvar s = 0; s <= CB; s++) begin : g_st
        localparam int J = CB - s;
        logic          src_vld;
        logic [DW-1:0] src_rem [0:NL-1];
        logic [CB:0]   src_q   [0:NL-1];
        logic [NW-1:0] src_na;
        logic [CB-1:0] src_aq;
        logic          src_nz;
        logic [DW-1:0] n_rem   [0:NL-1];
        logic [CB:0]   n_q     [0:NL-1];
        logic [DW-1:0] d;

        assign rdy[s] = !r_vld[s] || rdy[s+1];

        if (s == 0) begin : g_first
            // na / M by reciprocal: exact for na up to M*M
            logic [NW:0] a_sum;
            always_comb begin
                a_sum = (NW+1)'(i_na) + (NW+1)'(i_na >> CB) + (NW+1)'(1);
                src_vld = i_vld;
                for (int l = 0; l < NL; l++) begin
                    src_rem[l] = DW'(i_p[l]);
                    src_q[l]   = '0;
                end
                src_na   = i_na;
                src_aq   = a_sum[CB +: CB];
                src_nz   = (i_na != '0);
            end
        end else begin : g_next
            always_comb begin
                src_vld = r_vld[s-1];
                for (int l = 0; l < NL; l++) begin
                    src_rem[l] = r_rem[s-1][l];
                    src_q[l]   = r_q[s-1][l];
                end
                src_na   = r_na[s-1];
                src_aq   = r_aq[s-1];
                src_nz   = r_nz[s-1];
            end
        end

        always_comb begin
            d  = DW'(src_na) << J;
            for (int l = 0; l < NL; l++) begin
                n_rem[l] = src_rem[l];
                n_q[l]   = src_q[l];
                if (src_rem[l] >= d) begin
                    n_rem[l] = src_rem[l] - d;
                    n_q[l]   = src_q[l] | ((CB + 1)'(1) << J);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (rdy[s]) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[s] && src_vld) begin
                for (int l = 0; l < NL; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_q[s][l]   <= n_q[l];
                end
                r_na[s]   <= src_na;
                r_aq[s]   <= src_aq;
                r_nz[s]   <= src_nz;
            end
        end
    end

    assign o_vld = r_vld[CB];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (!r_nz[CB]) begin
                o_q[l] = '0;
            end else if (r_q[CB][l][CB]) begin
                o_q[l] = M;
            end else begin
                o_q[l] = r_q[CB][l][CB-1:0];
            end
        end
        o_alpha = r_nz[CB] ? r_aq[CB] : '0;
    end

endmodule

// File: bench/rgba8_over_and_blend_test.sv
// Testbench for rgba8_over_and_blend: queued stream driver, checking monitor, exact pixel predictor.
`timescale 1ns / 1ps

module rgba8_over_and_blend_test;

    localparam int CB = 8;
    localparam int IN_W = ((9*CB+7)/8)*8;
    localparam int OUT_W = ((4*CB+7)/8)*8;
    localparam int LAT = CB + 5;

    typedef struct packed {
        rgba_ob_pkg::t_cmd cmd;
        logic [7:0] fr, fg, fb, fa, br, bg, bb, ba, wt;
    } t_pixin;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    rgba8_over_and_blend #(.CHANNEL_BITS(CB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    t_pixin pending_px[$];
    logic [31:0] expected_px[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase = -1;
    int hold_cycles = 0;
    logic hold_done = 1'b0;
    int n_mismatch = 0;
    int n_checked = 0;
    int n_sent = 0;

    // premultiplied lerp of pixel "from" (f*) toward "to" (t*) by weight w
    function automatic logic [31:0] lerp_px(
        logic [7:0] fr, fg, fb, fa, logic [7:0] w, logic [7:0] tr, tg, tb, ta);
        longint na, p, q;
        logic [7:0] o[3];
        logic [7:0] fc[3];
        logic [7:0] tc[3];
        fc = '{fr, fg, fb};
        tc = '{tr, tg, tb};
        na = (255 - w) * fa + w * ta;
        if (na == 0) return 32'd0;
        for (int i = 0; i < 3; i++) begin
            p = (255 - w) * fa * fc[i] + w * ta * tc[i];
            q = p / na;
            o[i] = (q > 255) ? 8'd255 : q[7:0];
        end
        q = na / 255;
        return {q[7:0], o[2], o[1], o[0]};
    endfunction

    function automatic logic [31:0] composite_px(t_pixin x);
        logic [7:0] fr, fg, fb, br, bg, bb;
        fr = (x.fa == 0) ? 8'd0 : x.fr;
        fg = (x.fa == 0) ? 8'd0 : x.fg;
        fb = (x.fa == 0) ? 8'd0 : x.fb;
        br = (x.ba == 0) ? 8'd0 : x.br;
        bg = (x.ba == 0) ? 8'd0 : x.bg;
        bb = (x.ba == 0) ? 8'd0 : x.bb;
        if (x.cmd == rgba_ob_pkg::CMD_BLEND)
            return lerp_px(br, bg, bb, x.ba, x.wt, fr, fg, fb, x.fa);
        if (x.fa == 8'd255 || x.ba == 0) return {x.fa, fb, fg, fr};
        if (x.fa == 0) return {x.ba, bb, bg, br};
        return lerp_px(br, bg, bb, x.ba, x.fa, fr, fg, fb, 8'd255);
    endfunction

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_px(t_pixin x);
        pending_px.push_back(x);
        expected_px.push_back(composite_px(x));
    endtask

    task automatic drain();
        while (pending_px.size() != 0 || expected_px.size() != 0) @(posedge i_clk);
        repeat (LAT + 2) @(posedge i_clk);
    endtask

    // driver: next beat goes up when the current one was taken or none is offered
    always @(posedge i_clk) begin
        t_pixin nx;
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid) begin
                    void'(pending_px.pop_front());
                    n_sent++;
                end
                if (pending_px.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nx = pending_px[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {nx.wt, nx.ba, nx.bb, nx.bg, nx.br,
                                     nx.fa, nx.fb, nx.fg, nx.fr};
                    s_axis_tuser <= nx.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [31:0] exp_px;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_px.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: unexpected output beat %h", m_axis_tdata);
                end else begin
                    exp_px = expected_px.pop_front();
                    n_checked++;
                    if (m_axis_tdata[31:0] !== exp_px) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("ERROR: pixel %0d rgba exp %h got %h",
                                     n_checked, exp_px, m_axis_tdata[31:0]);
                    end
                end
            end
        end
    end

    // receiver backpressure; one long hold-off at the start of the first random phase
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else if (phase == 0 && !hold_done) begin
                hold_cycles <= 60;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        t_pixin x;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        x = '{rgba_ob_pkg::CMD_OVER, 8'd10, 8'd20, 8'd30, 8'd255,
              8'd1, 8'd2, 8'd3, 8'd128, 8'd0};
        push_px(x);
        x.fa = 8'd0; push_px(x);
        x.fa = 8'd100; x.ba = 8'd0; push_px(x);
        x.ba = 8'd255; push_px(x);
        x = '{rgba_ob_pkg::CMD_OVER, 8'd255, 8'd255, 8'd255, 8'd1,
              8'd255, 8'd0, 8'd255, 8'd1, 8'd255};
        push_px(x);
        x = '{rgba_ob_pkg::CMD_OVER, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        push_px(x);
        x.cmd = rgba_ob_pkg::CMD_BLEND; push_px(x);
        x = '{rgba_ob_pkg::CMD_BLEND, 8'd200, 8'd100, 8'd50, 8'd255,
              8'd5, 8'd6, 8'd7, 8'd255, 8'd0};
        push_px(x);
        x.wt = 8'd255; push_px(x);
        x.wt = 8'd128; push_px(x);
        x.fa = 8'd0; x.ba = 8'd0; push_px(x);
        x = '{rgba_ob_pkg::CMD_BLEND, 8'd255, 8'd255, 8'd255, 8'd1,
              8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
        push_px(x); // small new alpha
        x = '{rgba_ob_pkg::CMD_BLEND, 8'd255, 8'd255, 8'd255, 8'd255,
              8'd255, 8'd255, 8'd255, 8'd255, 8'd77};
        push_px(x);
        x = '{rgba_ob_pkg::CMD_BLEND, 8'd9, 8'd9, 8'd9, 8'd0,
              8'd200, 8'd200, 8'd200, 8'd3, 8'd255};
        push_px(x); // zero new alpha
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 9) : 0;
            recv_stall_pct = (ph == 2) ? 67 : ((ph == 3) ? 9 : 0);
            phase = ph;
            for (int k = 0; k < 135; k++) begin
                x.cmd = rgba_ob_pkg::t_cmd'($urandom_range(0, 1));
                x.fr = 8'($urandom); x.fg = 8'($urandom); x.fb = 8'($urandom);
                x.br = 8'($urandom); x.bg = 8'($urandom); x.bb = 8'($urandom);
                x.fa = pick_chan(); x.ba = pick_chan(); x.wt = pick_chan();
                push_px(x);
            end
            drain();
        end
        $display("Sent %0d and checked %0d pixels: over and blend, clear and opaque alpha,",
                 n_sent, n_checked);
        $display("full weight range, source gaps, sink stalls and a long sink hold-off.");
        if (n_mismatch == 0 && expected_px.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
